// ===== hw/rtl/element_group_tally_table_macros.svh =====
// assertion macros for the tally table checker
`ifndef ELEMENT_GROUP_TALLY_TABLE_MACROS_SVH
`define ELEMENT_GROUP_TALLY_TABLE_MACROS_SVH
// implication checked every clock, quiet in reset
`define EGT_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("egt check failed");
// next-cycle implication
`define EGT_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("egt check failed");
`endif

// ===== hw/rtl/egt_pkg.sv =====
// ----------------------------------------------------------------------------
// egt_pkg
// shared constants and types of the element group tally table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package egt_pkg;
  localparam int MAX_ATOMS    = 256;
  localparam int MAX_DISTINCT = 64;
  localparam int PW = $clog2(MAX_ATOMS);
  localparam int EW = $clog2(MAX_DISTINCT);
  localparam int CW = $clog2(MAX_ATOMS + 1);
  localparam int DW = $clog2(MAX_DISTINCT + 1);

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_COUNT = 2'd1;
  localparam logic [1:0] ACT_INST  = 2'd2;
  localparam logic [1:0] ACT_CLEAR = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_WALK, ST_WRITE, ST_DONE
  } state_t;

  // entry record in the entry memory
  typedef struct packed {
    logic [7:0]    id;
    logic [CW-1:0] cnt;
    logic [PW-1:0] first;
    logic [PW-1:0] last;
  } entry_t;

  function automatic logic is_halogen(input logic [7:0] id);
    return id == 8'd9 || id == 8'd17 || id == 8'd35 || id == 8'd53;
  endfunction
endpackage

// ===== hw/rtl/egt_ram.sv =====
// ----------------------------------------------------------------------------
// egt_ram
// generic single port synchronous ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module egt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== hw/rtl/element_group_tally_table.sv =====
// ----------------------------------------------------------------------------
// element_group_tally_table
// per-element tally table with position chains, load and query sequencer
// ----------------------------------------------------------------------------
// Usage: input words (action, element_id, instance_number) arrive on the
// in_ valid/ready channel, one result word per input leaves on out_.
// The generic halogen code is written on cfg_, by the user only while idle;
// the block itself does not enforce this. One item is handled at a time.
// A load or query scans the held entries, one entry memory read per cycle;
// a match ends the scan early, except in a halogen count, which sums every
// halogen entry. An instance query then walks the link memory one link per
// cycle. A clear skips the scan and goes straight to the result.
// The result sits in an output register; a new item is taken only once it
// has been taken, so a stalled receiver holds off the input side.
// Reset clears the counters and sequencer; memory contents are stale and
// are never read before written. The halogen code resets to 255.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module element_group_tally_table (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_action,
  input  logic [7:0]              in_element_id,
  input  logic [8:0]              in_instance_number,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [8:0]              out_occurrence_count,
  output logic [7:0]              out_atom_position,
  output logic                    out_error,
  output logic [6:0]              out_distinct_count,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [7:0]              cfg_data
);
  import egt_pkg::*;

  state_t state_r, state_nxt;
  logic [7:0]    hal_r;
  logic [DW-1:0] used_r;
  logic [CW-1:0] loaded_r;
  logic [1:0]    act_r;
  logic [7:0]    id_r;
  logic [CW-1:0] left_r;
  logic [DW-1:0] j_r;
  logic          rd_ok_r;
  logic [EW-1:0] hit_r;
  logic          found_r;
  logic [CW-1:0] sum_r;
  logic [PW-1:0] pos_r;
  logic          ovalid_r;
  logic [8:0]    ocnt_r;
  logic [7:0]    opos_r;
  logic          oerr_r;
  logic [6:0]    odist_r;

  // entry memory
  logic          e_we;
  logic [EW-1:0] e_addr;
  entry_t        e_wdata, e_rdata, hit_e_r;
  egt_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_DISTINCT)) u_entry (
    .clk(clk), .we(e_we), .addr(e_addr), .wdata(e_wdata), .rdata(e_rdata));

  // link memory
  logic          l_we;
  logic [PW-1:0] l_addr, l_wdata, l_rdata;
  egt_ram #(.WIDTH(PW), .DEPTH(MAX_ATOMS)) u_link (
    .clk(clk), .we(l_we), .addr(l_addr), .wdata(l_wdata), .rdata(l_rdata));

  logic halq;
  assign halq = (id_r == hal_r);
  assign in_ready  = (state_r == ST_IDLE) && !ovalid_r;
  assign cfg_ready = 1'b1;
  assign out_valid = ovalid_r;
  assign out_occurrence_count = ocnt_r;
  assign out_atom_position = opos_r;
  assign out_error = oerr_r;
  assign out_distinct_count = odist_r;

  // match test on the entry read last cycle
  logic e_match;
  always_comb begin
    if (act_r == ACT_LOAD || !halq)
      e_match = (e_rdata.id == id_r) && (act_r != ACT_INST || left_r <= e_rdata.cnt);
    else e_match = is_halogen(e_rdata.id) && (act_r == ACT_COUNT ||
                   left_r <= e_rdata.cnt);
  end

  logic scan_end;
  assign scan_end = (j_r >= used_r) && !rd_ok_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid && in_ready) begin
        if (in_action == ACT_CLEAR) state_nxt = ST_DONE;
        else state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (rd_ok_r && e_match && !(act_r == ACT_COUNT && halq)) begin
          if (act_r == ACT_INST) state_nxt = ST_WALK;
          else state_nxt = ST_WRITE;
        end else if (scan_end) state_nxt = ST_WRITE;
      end
      ST_WALK:  if (left_r <= 1) state_nxt = ST_DONE;
      ST_WRITE: state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    e_we = 1'b0;
    e_addr = j_r[EW-1:0];
    e_wdata = hit_e_r;
    l_we = 1'b0;
    l_addr = pos_r;
    l_wdata = loaded_r[PW-1:0];
    if (state_r == ST_WALK && left_r > 1 && rd_ok_r) l_addr = l_rdata;
    if (state_r == ST_WRITE && act_r == ACT_LOAD && loaded_r < CW'(MAX_ATOMS)) begin
      if (found_r) begin
        e_we = 1'b1;
        e_addr = hit_r;
        e_wdata.cnt = hit_e_r.cnt + 1'b1;
        e_wdata.last = loaded_r[PW-1:0];
        l_we = 1'b1;
        l_addr = hit_e_r.last;
      end else if (used_r < DW'(MAX_DISTINCT)) begin
        e_we = 1'b1;
        e_addr = used_r[EW-1:0];
        e_wdata.id = id_r;
        e_wdata.cnt = CW'(1);
        e_wdata.first = loaded_r[PW-1:0];
        e_wdata.last = loaded_r[PW-1:0];
      end
    end
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      hal_r <= 8'd255;
      used_r <= '0;
      loaded_r <= '0;
      ovalid_r <= 1'b0;
      rd_ok_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) hal_r <= cfg_data;
      if (ovalid_r && out_ready) ovalid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: if (in_valid && in_ready) begin
          act_r <= in_action;
          id_r <= in_element_id;
          left_r <= in_instance_number;
          j_r <= '0;
          rd_ok_r <= 1'b0;
          found_r <= 1'b0;
          sum_r <= '0;
          oerr_r <= 1'b0;
          if (in_action == ACT_CLEAR) begin
            used_r <= '0;
            loaded_r <= '0;
          end
        end
        ST_SCAN: begin
          rd_ok_r <= (j_r < used_r) && !(state_nxt != ST_SCAN);
          if (j_r < used_r) j_r <= j_r + 1'b1;
          if (rd_ok_r) begin
            if (act_r == ACT_COUNT && halq) begin
              if (is_halogen(e_rdata.id)) sum_r <= sum_r + e_rdata.cnt;
            end else if (e_match) begin
              found_r <= 1'b1;
              hit_r <= EW'(j_r - 1'b1);
              hit_e_r <= e_rdata;
              pos_r <= e_rdata.first;
            end else if (act_r == ACT_INST && halq && is_halogen(e_rdata.id))
              left_r <= left_r - e_rdata.cnt;
          end
        end
        ST_WALK: begin
          rd_ok_r <= 1'b1;
          if (left_r > 1) begin
            left_r <= left_r - 1'b1;
            if (rd_ok_r) pos_r <= l_rdata;
          end
        end
        ST_WRITE: begin
          if (act_r == ACT_LOAD) begin
            // a load that meets either full table is refused
            found_r <= loaded_r < CW'(MAX_ATOMS) &&
                       (found_r || used_r < DW'(MAX_DISTINCT));
            if (loaded_r < CW'(MAX_ATOMS) &&
                (found_r || used_r < DW'(MAX_DISTINCT))) begin
              if (!found_r) used_r <= used_r + 1'b1;
              loaded_r <= loaded_r + 1'b1;
              pos_r <= loaded_r[PW-1:0];
            end
          end
        end
        ST_DONE: begin
          ovalid_r <= 1'b1;
          odist_r <= 7'(used_r);
          unique case (act_r)
            ACT_COUNT: begin
              opos_r <= '0;
              if (halq) begin
                ocnt_r <= 9'(sum_r);
                oerr_r <= (sum_r == 0);
              end else begin
                ocnt_r <= found_r ? 9'(hit_e_r.cnt) : 9'd0;
                oerr_r <= !found_r;
              end
            end
            ACT_CLEAR: begin
              ocnt_r <= '0;
              opos_r <= '0;
            end
            default: begin
              ocnt_r <= 9'(loaded_r);
              oerr_r <= !found_r || (act_r == ACT_INST && left_r == 0);
              if (!found_r || (act_r == ACT_INST && left_r == 0)) opos_r <= '0;
              else opos_r <= 8'(pos_r);
            end
          endcase
        end
        default: ;
      endcase
      if (state_r == ST_WALK && left_r <= 1 && rd_ok_r) pos_r <= l_rdata;
    end
  end
endmodule

// ===== hw/rtl/egt_checker.sv =====
// ----------------------------------------------------------------------------
// egt_checker
// port level checks of the tally table, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "element_group_tally_table_macros.svh"
module egt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_atom_position,
  input logic       out_error,
  input logic [6:0] out_distinct_count
);
  // stalled result word holds
  `EGT_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_atom_position))
  // no input taken while a result waits
  `EGT_ASSERT_IMP(a_one, clk, rst_n, out_valid, !in_ready)
  // error results carry no position
  `EGT_ASSERT_IMP(a_err, clk, rst_n, out_valid && out_error, out_atom_position == 8'd0)
  // distinct count never exceeds table depth
  `EGT_ASSERT_IMP(a_dist, clk, rst_n, out_valid, out_distinct_count <= 7'd64)
endmodule

bind element_group_tally_table egt_checker u_egt_checker (.*);
